@@ hw/rtl/dhb_pkg.sv @@
// Shared types and constants for the decimating history buffer.
// Used by every module of the block except dhb_ram; depends on nothing else.
`timescale 1ns / 1ps

package dhb_pkg;

	// Defaults for the top-level parameters.
	localparam int MAX_HALF_DEFAULT   = 512;
	localparam int DATA_WIDTH_DEFAULT = 32;

	// Fixed field widths of the request and result words, the half size and the skip counter.
	localparam int SAMPLE_W = 32;
	localparam int INDEX_W  = 10;
	localparam int HALF_W   = 10;
	localparam int COUNT_W  = 11;
	localparam int STEP_W   = 5;
	localparam int SKIP_W   = 32;

	// The largest half size that the configuration register can express.
	localparam int HALF_REG_MAX = 1023;

	localparam logic [HALF_W-1:0] HALF_RESET = 10'd512;
	localparam logic [STEP_W-1:0] STEP_MAX   = 5'd31;

	// Request modes.
	localparam logic [1:0] MODE_STORE = 2'd0;
	localparam logic [1:0] MODE_READ  = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;

	typedef struct packed {
		logic [1:0]          mode;
		logic [SAMPLE_W-1:0] sample_value;
		logic [INDEX_W-1:0]  read_index;
	} request_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] read_data;
		logic                read_valid;
		logic [COUNT_W-1:0]  stored_count;
		logic [STEP_W-1:0]   step_exponent;
	} result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_COMPACT
	} state_t;

endpackage

@@ hw/rtl/dhb_ram.sv @@
// Simple dual-port history memory: one write port, one registered read port.
// Stand-alone; its sizes come from the parameters of its user.
`timescale 1ns / 1ps

module dhb_ram #(
	parameter int DEPTH  = 1024,
	parameter int ADDR_W = 10,
	parameter int DW     = 32
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DW-1:0]     wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DW-1:0]     rdata
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ hw/rtl/dhb_ctrl.sv @@
// Sequencer and history state for the decimating history buffer.
// Depends on dhb_pkg; drives the ports of dhb_ram.
`timescale 1ns / 1ps

module dhb_ctrl #(
	parameter int ADDR_W = 11,
	parameter int DW     = dhb_pkg::DATA_WIDTH_DEFAULT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       clr,
	input  logic [dhb_pkg::HALF_W-1:0] h,
	input  logic                       start,
	input  dhb_pkg::request_t          request,
	output logic                       busy,
	output logic                       done,
	output dhb_pkg::result_t           result,
	output logic                       ram_we,
	output logic [ADDR_W-1:0]          ram_waddr,
	output logic [DW-1:0]              ram_wdata,
	output logic                       ram_re,
	output logic [ADDR_W-1:0]          ram_raddr,
	input  logic [DW-1:0]              ram_rdata
);

	localparam int CW = dhb_pkg::COUNT_W;
	localparam int SW = dhb_pkg::STEP_W;
	localparam int KW = dhb_pkg::SKIP_W;
	localparam int HW = dhb_pkg::HALF_W;

	dhb_pkg::state_t state_q, state_d;

	logic [CW-1:0] fill_q, fill_d;
	logic [SW-1:0] step_q, step_d;
	logic [KW-1:0] skip_q, skip_d;
	logic [HW-1:0] cnt_q, cnt_d;
	logic          mv_s1, mv_d;
	logic [HW-1:0] wa_s1, wa_d;
	logic          rv_q, rv_d;
	logic          done_q, done_d;
	dhb_pkg::result_t res_q, res_d;

	logic          keep;
	logic [CW-1:0] fill_inc;
	logic          full;
	logic [SW-1:0] step_up;
	logic [KW-1:0] skip_reload;
	logic [KW-1:0] skip_reload_up;

	assign keep           = (skip_q == '0);
	assign fill_inc       = fill_q + CW'(keep);
	assign full           = keep && (fill_inc == {h, 1'b0});
	assign step_up        = (step_q == dhb_pkg::STEP_MAX) ? dhb_pkg::STEP_MAX : step_q + SW'(1);
	// 2^step - 1: the reload already accounts for the decrement of this item.
	assign skip_reload    = ~({KW{1'b1}} << step_q);
	assign skip_reload_up = ~({KW{1'b1}} << step_up);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dhb_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		fill_d    = fill_q;
		step_d    = step_q;
		skip_d    = skip_q;
		cnt_d     = cnt_q;
		mv_d      = 1'b0;
		wa_d      = cnt_q;
		rv_d      = rv_q;
		done_d    = 1'b0;
		res_d     = res_q;
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = '0;
		busy      = (state_q != dhb_pkg::ST_IDLE);

		case (state_q)
			dhb_pkg::ST_IDLE: begin
				if (start) begin
					res_d.read_data     = '0;
					res_d.read_valid    = 1'b0;
					res_d.stored_count  = fill_q;
					res_d.step_exponent = step_q;
					case (request.mode)
						dhb_pkg::MODE_STORE: begin
							if (keep) begin
								ram_we    = 1'b1;
								ram_waddr = ADDR_W'(fill_q);
								ram_wdata = DW'(request.sample_value);
							end
							if (full) begin
								state_d = dhb_pkg::ST_COMPACT;
								cnt_d   = '0;
							end else begin
								fill_d             = fill_inc;
								skip_d             = keep ? skip_reload : skip_q - KW'(1);
								done_d             = 1'b1;
								res_d.stored_count = fill_inc;
							end
						end
						dhb_pkg::MODE_READ: begin
							ram_re    = 1'b1;
							ram_raddr = ADDR_W'(request.read_index);
							rv_d      = ({1'b0, request.read_index} < fill_q);
							state_d   = dhb_pkg::ST_READ;
						end
						dhb_pkg::MODE_CLEAR: begin
							fill_d              = '0;
							step_d              = '0;
							skip_d              = '0;
							done_d              = 1'b1;
							res_d.stored_count  = '0;
							res_d.step_exponent = '0;
						end
						default: begin
							done_d = 1'b1;
						end
					endcase
				end
			end
			dhb_pkg::ST_READ: begin
				done_d              = 1'b1;
				res_d.read_data     = rv_q ? dhb_pkg::SAMPLE_W'(ram_rdata) : '0;
				res_d.read_valid    = rv_q;
				res_d.stored_count  = fill_q;
				res_d.step_exponent = step_q;
				state_d             = dhb_pkg::ST_IDLE;
			end
			dhb_pkg::ST_COMPACT: begin
				// Entry 2i+1 is read in one cycle and written to entry i in the next.
				ram_we    = mv_s1;
				ram_waddr = ADDR_W'(wa_s1);
				ram_wdata = ram_rdata;
				if (cnt_q != h) begin
					ram_re    = 1'b1;
					ram_raddr = ADDR_W'({cnt_q, 1'b1});
					mv_d      = 1'b1;
					wa_d      = cnt_q;
					cnt_d     = cnt_q + HW'(1);
				end else begin
					step_d              = step_up;
					skip_d              = skip_reload_up;
					fill_d              = {1'b0, h};
					done_d              = 1'b1;
					res_d.read_data     = '0;
					res_d.read_valid    = 1'b0;
					res_d.stored_count  = {1'b0, h};
					res_d.step_exponent = step_up;
					state_d             = dhb_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = dhb_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			step_q <= '0;
			skip_q <= '0;
			cnt_q  <= '0;
			mv_s1  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			cnt_q  <= cnt_d;
			mv_s1  <= mv_d;
			done_q <= done_d;
			if (clr) begin
				fill_q <= '0;
				step_q <= '0;
				skip_q <= '0;
			end else begin
				fill_q <= fill_d;
				step_q <= step_d;
				skip_q <= skip_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		wa_s1 <= wa_d;
		rv_q  <= rv_d;
		res_q <= res_d;
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

@@ hw/rtl/decimating_history_buffer_unit.sv @@
// Top level of the decimating history buffer: configuration register,
// sequencer and history memory. Depends on dhb_pkg, dhb_ctrl and dhb_ram.
`timescale 1ns / 1ps

// The block records a decimated history of sample words in a memory of twice the
// largest supported half size and answers one result for every request. A request
// is taken when start is high and busy is low. Its result appears on result for
// exactly one cycle, marked by done; the receiver cannot stall it, so it must take
// every result as it comes. A store that does not fill the history, or a clear
// request, leaves busy low and its result shows in the cycle after acceptance, so
// these may be issued every cycle. A read request raises busy for one cycle,
// because the history memory has a registered read port, and its result passes
// from that read register through the read state into the result register. A
// store that fills the history starts a compaction that moves every odd-numbered
// entry down to the lower half, one entry per cycle through the single read and
// write port of the memory: busy then stays high until the compaction ends and the
// result follows. At least half size kept samples lie between two compactions.
// Writing the half size register also clears the history; it must only be written
// while the block is idle. The history memory is not cleared after reset, so no
// clearing pass is needed: the fill count alone bounds what a read may see. A half
// size of zero acts as one, and values above MAX_HALF act as MAX_HALF.
module decimating_history_buffer_unit #(
	parameter int MAX_HALF   = dhb_pkg::MAX_HALF_DEFAULT,
	parameter int DATA_WIDTH = dhb_pkg::DATA_WIDTH_DEFAULT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  dhb_pkg::request_t          request,
	output logic                       done,
	output dhb_pkg::result_t           result,
	input  logic                       cfg_we,
	input  logic [dhb_pkg::HALF_W-1:0] cfg_wdata
);

	// The register cannot name a half size above its own range, so the memory
	// never needs more than twice that.
	localparam int HMAX   = (MAX_HALF < dhb_pkg::HALF_REG_MAX) ? MAX_HALF
	                                                           : dhb_pkg::HALF_REG_MAX;
	localparam int DEPTH  = 2 * HMAX;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int HW     = dhb_pkg::HALF_W;

	logic [HW-1:0]         half_size_q;
	logic [HW-1:0]         h_eff;
	logic                  ram_we;
	logic [ADDR_W-1:0]     ram_waddr;
	logic [DATA_WIDTH-1:0] ram_wdata;
	logic                  ram_re;
	logic [ADDR_W-1:0]     ram_raddr;
	logic [DATA_WIDTH-1:0] ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_size_q <= dhb_pkg::HALF_RESET;
		end else if (cfg_we) begin
			half_size_q <= cfg_wdata;
		end
	end

	// Effective half size, clamped into the range the memory supports.
	always_comb begin
		if (half_size_q == '0) begin
			h_eff = HW'(1);
		end else if (half_size_q > HW'(HMAX)) begin
			h_eff = HW'(HMAX);
		end else begin
			h_eff = half_size_q;
		end
	end

	dhb_ctrl #(
		.ADDR_W (ADDR_W),
		.DW     (DATA_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.clr       (cfg_we),
		.h         (h_eff),
		.start     (start),
		.request   (request),
		.busy      (busy),
		.done      (done),
		.result    (result),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	dhb_ram #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W),
		.DW     (DATA_WIDTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

@@ hw/rtl/dhb_checker.sv @@
// Port-level checks for the decimating history buffer, bound to its top level.
// Depends on dhb_pkg and decimating_history_buffer_unit.
`timescale 1ns / 1ps

module dhb_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input dhb_pkg::request_t request,
	input logic              done,
	input dhb_pkg::result_t  result
);

	// Every result belongs to a request accepted or still in progress in the previous cycle.
	a_done_has_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(start && !busy) || $past(busy)))
		else $error("result without a request in progress");

	a_invalid_reads_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.read_valid) |-> (result.read_data == '0))
		else $error("read data not zero on an invalid result");

	a_valid_needs_entries: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.read_valid) |-> (result.stored_count != '0))
		else $error("valid read from an empty history");

	a_clear_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && request.mode == dhb_pkg::MODE_CLEAR) |=>
		(done && result.stored_count == '0 && result.step_exponent == '0))
		else $error("clear request did not report an empty history");

	a_read_holds_off: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && request.mode == dhb_pkg::MODE_READ) |=> (busy && !done))
		else $error("read request did not occupy the memory port");

endmodule

bind decimating_history_buffer_unit dhb_checker u_dhb_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.request (request),
	.done    (done),
	.result  (result)
);

@@ sim/tb_decimating_history_buffer_unit.sv @@
// Self-checking testbench for decimating_history_buffer_unit: directed and random
// store, read and clear requests across several half sizes, checked against a
// behavioral history model kept here. Depends on dhb_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_decimating_history_buffer_unit;

	import dhb_pkg::*;

	// The one mode code the package leaves unnamed; the block must ignore it.
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	localparam int MAX_HALF     = MAX_HALF_DEFAULT;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int SETTLE_CYCLES = 4;
	localparam int TAIL_CYCLES  = 8;

	// Work items for the driver: a request, a half size write, or a pause that
	// holds the next item back until every outstanding result has come home.
	typedef enum logic [1:0] {
		JOB_REQUEST,
		JOB_HALF_WRITE,
		JOB_DRAIN
	} job_kind_e;

	typedef struct {
		job_kind_e          kind;
		request_t           rq;
		logic [HALF_W-1:0]  half;
		bit                 steady;
	} job_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	request_t          request = '0;
	logic              done;
	result_t           result;
	logic              cfg_we = 1'b0;
	logic [HALF_W-1:0] cfg_wdata = '0;

	job_t    pending_jobs[$];
	result_t expected_results[$];
	int      fail_count = 0;
	int      cycle_count = 0;
	int      settle_count = 0;

	// Model of the block's state: the history words, the fill count, the step
	// exponent, the skip counter and the half size register.
	logic [SAMPLE_W-1:0] history_words [2*MAX_HALF];
	logic [COUNT_W-1:0]  fill_level = '0;
	logic [STEP_W-1:0]   step_log2 = '0;
	logic [SKIP_W-1:0]   skip_left = '0;
	logic [HALF_W-1:0]   half_reg = HALF_RESET;

	decimating_history_buffer_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.request   (request),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Apply one request to the history model and return the result it should
	// produce. A store keeps the sample only when the skip counter has run out;
	// once the history holds twice the effective half size, the odd entries
	// move down to the lower half and the step doubles (saturating at 2^31).
	function automatic result_t advance_history(request_t rq);
		result_t     res;
		int unsigned half_eff;
		res = '0;
		half_eff = (half_reg == 0) ? 1 : ((half_reg > MAX_HALF) ? MAX_HALF : half_reg);
		case (rq.mode)
			MODE_STORE: begin
				if (skip_left == 0) begin
					history_words[fill_level[INDEX_W-1:0]] = rq.sample_value;
					fill_level = fill_level + COUNT_W'(1);
					skip_left = 32'd1 << step_log2;
				end
				if (fill_level >= 2 * half_eff) begin
					for (int i = 0; i < half_eff; i++)
						history_words[i] = history_words[2*i+1];
					if (step_log2 < STEP_MAX)
						step_log2 = step_log2 + STEP_W'(1);
					skip_left = 32'd1 << step_log2;
					fill_level = COUNT_W'(half_eff);
				end
				skip_left = skip_left - SKIP_W'(1);
			end
			MODE_READ: begin
				if (rq.read_index < fill_level) begin
					res.read_data = history_words[rq.read_index];
					res.read_valid = 1'b1;
				end
			end
			MODE_CLEAR: begin
				fill_level = '0;
				step_log2 = '0;
				skip_left = '0;
			end
			default: begin
				// The unused mode leaves the history untouched.
			end
		endcase
		res.stored_count = fill_level;
		res.step_exponent = step_log2;
		return res;
	endfunction

	function void check_field(string what, longint unsigned want, longint unsigned got);
		if (want != got) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
		end
	endfunction

	// Driver. Each edge it retires an accepted request, then decides what the
	// next cycle carries. A half size write or a pause waits until the block is
	// quiet: no result outstanding, none on the output this cycle, busy low and
	// no request on offer. Every driven signal gets exactly one assignment.
	always @(posedge clk) begin
		logic              next_start;
		request_t          next_req;
		logic              next_we;
		logic [HALF_W-1:0] next_wdata;
		job_t              job;
		bit                quiet;
		next_start = start;
		next_req = request;
		next_we = 1'b0;
		next_wdata = cfg_wdata;
		if (arst_n) begin
			if (start && !busy)
				next_start = 1'b0;
			quiet = expected_results.size() == 0 && !done && !busy && !start;
			if (!next_start && !cfg_we && pending_jobs.size() != 0) begin
				job = pending_jobs[0];
				if (job.kind == JOB_REQUEST) begin
					// Roughly a third of the cycles stay idle, except in the
					// steady stretch where requests go back to back.
					if (job.steady || $urandom_range(99) >= 32) begin
						next_start = 1'b1;
						next_req = job.rq;
						void'(pending_jobs.pop_front());
					end
				end else if (quiet) begin
					settle_count++;
					if (settle_count >= SETTLE_CYCLES) begin
						settle_count = 0;
						void'(pending_jobs.pop_front());
						if (job.kind == JOB_HALF_WRITE) begin
							next_we = 1'b1;
							next_wdata = job.half;
						end
					end
				end else begin
					settle_count = 0;
				end
			end
		end
		start <= next_start;
		request <= next_req;
		cfg_we <= next_we;
		cfg_wdata <= next_wdata;
	end

	// Monitor. Results are checked first, then the model takes any register
	// write and any request accepted at this edge, so the order of checks and
	// predictions is fixed within one process.
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (done) begin
				if (expected_results.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result, expected none, actual %0h",
						$time, result);
				end else begin
					want = expected_results.pop_front();
					check_field("read_data", want.read_data, result.read_data);
					check_field("read_valid", want.read_valid, result.read_valid);
					check_field("stored_count", want.stored_count, result.stored_count);
					check_field("step_exponent", want.step_exponent, result.step_exponent);
				end
			end
			if (cfg_we) begin
				// A half size write also empties the history.
				half_reg = cfg_wdata;
				fill_level = '0;
				step_log2 = '0;
				skip_left = '0;
			end
			if (start && !busy)
				expected_results.push_back(advance_history(request));
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic add_request(logic [1:0] m, logic [SAMPLE_W-1:0] s,
			logic [INDEX_W-1:0] ix, bit steady = 1'b0);
		job_t job;
		job.kind = JOB_REQUEST;
		job.rq.mode = m;
		job.rq.sample_value = s;
		job.rq.read_index = ix;
		job.half = '0;
		job.steady = steady;
		pending_jobs.push_back(job);
	endtask

	task automatic add_marker(job_kind_e kind, logic [HALF_W-1:0] h = '0);
		job_t job;
		job.kind = kind;
		job.rq = '0;
		job.half = h;
		job.steady = 1'b0;
		pending_jobs.push_back(job);
	endtask

	initial begin
		int          phase_half [12];
		int          phase_items [12];
		int unsigned half_eff;
		int unsigned idx_top;
		int unsigned pick;
		logic [1:0]  m;

		// Half size settings for the random phases. Small sizes compact often
		// and push the step up; the largest ones mostly exercise reads.
		phase_half = '{1, 0, 2, 3, 5, 16, 1023, 24, 512, 513, 1, 1};
		phase_items = '{110, 60, 100, 100, 100, 100, 60, 120, 60, 60, 60, 80};
		phase_half[10] = $urandom_range(1023, 1);
		phase_half[11] = $urandom_range(8, 1);

		// Directed part with the reset half size: reads of an empty history,
		// the unused mode, extreme sample words, reads at and past the fill
		// count, the top index, and a clear.
		add_request(MODE_READ, 32'h0, 10'd0);
		add_request(MODE_UNUSED, $urandom(), 10'd1023);
		add_request(MODE_STORE, 32'h0000_0000, 10'd0);
		add_request(MODE_STORE, 32'hFFFF_FFFF, 10'd1023);
		add_request(MODE_STORE, 32'hA5A5_5A5A, 10'd0);
		add_request(MODE_READ, $urandom(), 10'd0);
		add_request(MODE_READ, $urandom(), 10'd1);
		add_request(MODE_READ, $urandom(), 10'd2);
		add_request(MODE_READ, $urandom(), 10'd3);
		add_request(MODE_READ, $urandom(), 10'd1023);
		add_request(MODE_CLEAR, $urandom(), 10'd0);
		add_request(MODE_READ, $urandom(), 10'd0);
		add_request(MODE_STORE, $urandom(), 10'd0);

		// Smallest half size: from the second kept sample on, every kept sample compacts the history.
		add_marker(JOB_HALF_WRITE, 10'd1);
		for (int i = 0; i < 6; i++)
			add_request(MODE_STORE, $urandom(), 10'd0);
		add_request(MODE_READ, 32'h0, 10'd0);
		add_request(MODE_READ, 32'h0, 10'd1);

		// A half size of zero acts as one; all ones acts as the maximum.
		add_marker(JOB_HALF_WRITE, 10'd0);
		for (int i = 0; i < 3; i++)
			add_request(MODE_STORE, $urandom(), 10'd0);
		add_request(MODE_READ, 32'h0, 10'd0);
		add_marker(JOB_HALF_WRITE, 10'd1023);
		add_request(MODE_STORE, 32'hFFFF_FFFF, 10'd0);
		add_request(MODE_READ, 32'h0, 10'd0);

		// Random phases: mostly stores and reads aimed near the fill range,
		// with a few clears, unused modes and reads anywhere in the index space.
		for (int p = 0; p < 12; p++) begin
			add_marker(JOB_HALF_WRITE, HALF_W'(phase_half[p]));
			half_eff = (phase_half[p] == 0) ? 1 :
				((phase_half[p] > MAX_HALF) ? MAX_HALF : phase_half[p]);
			idx_top = 2 * half_eff + 1;
			if (idx_top > 1023)
				idx_top = 1023;
			for (int n = 0; n < phase_items[p]; n++) begin
				// Once, mid-phase, hold everything back until the block is empty.
				if (p == 4 && n == 50)
					add_marker(JOB_DRAIN);
				pick = $urandom_range(99);
				if (pick < 60)
					m = MODE_STORE;
				else if (pick < 96)
					m = MODE_READ;
				else if (pick < 97)
					m = MODE_CLEAR;
				else
					m = MODE_UNUSED;
				add_request(m, $urandom(),
					INDEX_W'(($urandom_range(9) == 0) ? $urandom_range(1023)
					                                  : $urandom_range(idx_top)),
					p == 3);
			end
			add_marker(JOB_DRAIN);
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		@(negedge clk);
		while (pending_jobs.size() != 0 || start || expected_results.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
